>>> src/deq_pkg.sv
// shared types and constants for the double-ended queue
// no dependencies; used by deq_cell and double_ended_queue
package deq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int KIND_W = 2;
  localparam int OCC_W = 5;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 2'd3;

  typedef logic signed [WORD_W-1:0] word_t;

  // one-hot strobe broadcast to every cell; already gated by full/empty
  typedef struct packed {
    logic ins_front;
    logic ins_back;
    logic rem_front;
    logic rem_back;
  } deq_ctl_t;

endpackage

>>> src/deq_cell.sv
// one storage cell of the shifting deque row
// depends on deq_pkg; instantiated in a chain by double_ended_queue
module deq_cell (
  input  logic             clk,
  input  logic             rst,
  input  deq_pkg::deq_ctl_t ctl,
  input  deq_pkg::word_t   push_word,
  input  deq_pkg::word_t   left_word,
  input  logic             left_occ,
  input  deq_pkg::word_t   right_word,
  input  logic             right_occ,
  output deq_pkg::word_t   word,
  output logic             occ,
  output logic             tail
);

  deq_pkg::word_t word_next;
  logic           occ_next;

  assign tail = occ & ~right_occ;

  always_comb begin
    word_next = word;
    occ_next  = occ;
    if (ctl.ins_front) begin
      // whole row moves one place toward the back
      word_next = left_word;
      occ_next  = left_occ;
    end else if (ctl.ins_back) begin
      // first free cell takes the word
      if (!occ && left_occ) begin
        word_next = push_word;
        occ_next  = 1'b1;
      end
    end else if (ctl.rem_front) begin
      word_next = right_word;
      occ_next  = right_occ;
    end else if (ctl.rem_back) begin
      if (tail) begin
        occ_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

endmodule

>>> src/double_ended_queue.sv
// bounded double-ended queue of signed 32-bit words, top level
// depends on deq_pkg and deq_cell
//
// usage: the request channel (req_valid/req_stall) takes one item per
// accepted edge: kind selects push front, push back, pop front or pop
// back, value is the word for pushes. every item gives exactly one
// item on the response channel (rsp_valid/rsp_stall): popped word
// (-1 on underflow, 0 for pushes), underflow, overflow and occupancy
// after the operation.
// storage is a row of DEPTH cells; a front push or pop shifts the whole
// row by one cell in the same cycle, a back push or pop touches only
// the boundary cell.
// latency: the response is valid the cycle after the request is taken.
// throughput: one item per cycle while the response side does not stall.
// a full push is dropped with overflow, an empty pop changes nothing.
// when rsp_stall is high with a pending response, req_stall goes high and
// the held response does not change.
// reset (rst, synchronous) empties the queue and drops any pending
// response; stored words are not cleared.
module double_ended_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [deq_pkg::KIND_W-1:0]   kind,
  input  logic signed [31:0]           value,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic signed [31:0]           popped,
  output logic                         underflow,
  output logic                         overflow,
  output logic [deq_pkg::OCC_W-1:0]    occupancy
);

  localparam int N = deq_pkg::DEPTH;

  deq_pkg::word_t           cell_word [N];
  logic [N-1:0]             cell_occ;
  logic [N-1:0]             cell_tail;
  logic [deq_pkg::CNT_W-1:0] count;
  logic [deq_pkg::CNT_W-1:0] count_next;
  deq_pkg::deq_ctl_t        ctl;
  logic                     take;
  logic                     full;
  logic                     empty;
  deq_pkg::word_t           back_word;
  deq_pkg::word_t           popped_next;
  logic                     underflow_next;
  logic                     overflow_next;

  assign req_stall = rsp_valid & rsp_stall;
  assign take      = req_valid & ~req_stall;
  assign full      = cell_occ[N-1];
  assign empty     = ~cell_occ[0];

  always_comb begin
    ctl            = '0;
    popped_next    = '0;
    underflow_next = 1'b0;
    overflow_next  = 1'b0;
    count_next     = count;
    case (kind)
      deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: begin
        if (full) begin
          overflow_next = 1'b1;
        end else begin
          ctl.ins_front = take & (kind == deq_pkg::KIND_PUSH_FRONT);
          ctl.ins_back  = take & (kind == deq_pkg::KIND_PUSH_BACK);
          count_next    = count + 1'b1;
        end
      end
      deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK: begin
        if (empty) begin
          underflow_next = 1'b1;
          popped_next    = '1;
        end else begin
          ctl.rem_front = take & (kind == deq_pkg::KIND_POP_FRONT);
          ctl.rem_back  = take & (kind == deq_pkg::KIND_POP_BACK);
          popped_next   = (kind == deq_pkg::KIND_POP_FRONT) ? cell_word[0] : back_word;
          count_next    = count - 1'b1;
        end
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  // one-hot tail select over the row
  always_comb begin
    back_word = '0;
    for (int i = 0; i < N; i++) begin
      back_word = back_word | (cell_word[i] & {deq_pkg::WORD_W{cell_tail[i]}});
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    deq_pkg::word_t lw;
    deq_pkg::word_t rw;
    logic           lo;
    logic           ro;
    if (i == 0) begin : g_first
      assign lw = value;
      assign lo = 1'b1;
    end else begin : g_mid_l
      assign lw = cell_word[i-1];
      assign lo = cell_occ[i-1];
    end
    if (i == N - 1) begin : g_last
      assign rw = '0;
      assign ro = 1'b0;
    end else begin : g_mid_r
      assign rw = cell_word[i+1];
      assign ro = cell_occ[i+1];
    end
    deq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .push_word  (value),
      .left_word  (lw),
      .left_occ   (lo),
      .right_word (rw),
      .right_occ  (ro),
      .word       (cell_word[i]),
      .occ        (cell_occ[i]),
      .tail       (cell_tail[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (take) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    if (take) begin
      popped    <= popped_next;
      underflow <= underflow_next;
      overflow  <= overflow_next;
      occupancy <= deq_pkg::OCC_W'(count_next);
    end
  end

`ifndef SYNTH
  a_count_matches_row: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_occ) == 32'(count))
    else $error("count disagrees with occupied cells");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= N)
    else $error("count exceeds depth");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(underflow && overflow))
    else $error("underflow and overflow together");

  a_underflow_word: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && underflow) |-> (popped == -32'sd1))
    else $error("underflow item without -1");

  a_row_contiguous: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_tail))
    else $error("occupied cells not contiguous");
`endif

endmodule

>>> sim/double_ended_queue_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for double_ended_queue: directed table, then random ops
// depends on deq_pkg and the double_ended_queue rtl
module double_ended_queue_tb;

  localparam int CLK_PERIOD = 4;
  localparam int MAX_CYCLES = 200000;
  localparam int PHASE_ITEMS = 375;
  localparam int EXP_DEPTH = 2048;
  localparam int MAX_ROWS = 32;

  typedef struct packed {
    logic signed [deq_pkg::WORD_W-1:0] popped;
    logic underflow;
    logic overflow;
    logic [deq_pkg::OCC_W-1:0] occupancy;
  } deq_result_t;

  typedef struct {
    logic [deq_pkg::KIND_W-1:0] op;
    deq_pkg::word_t word;
    bit typed;
    deq_result_t exp;
  } deq_row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  logic [deq_pkg::KIND_W-1:0] kind;
  logic signed [31:0] value;
  logic rsp_valid;
  logic rsp_stall;
  logic signed [31:0] popped;
  logic underflow;
  logic overflow;
  logic [deq_pkg::OCC_W-1:0] occupancy;

  double_ended_queue dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .kind(kind),
    .value(value),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .popped(popped),
    .underflow(underflow),
    .overflow(overflow),
    .occupancy(occupancy)
  );

  // predictor state
  deq_pkg::word_t store [deq_pkg::DEPTH];
  int front_ptr;
  int back_ptr;
  int held;

  // expected items, ring indexed by running write and read counts
  deq_result_t expected_results [EXP_DEPTH];
  int exp_wr;
  int exp_rd;
  deq_row_t directed_rows [MAX_ROWS];
  int row_count;
  int mismatches;
  int cycle_count;
  int sender_idle_pct;
  int rsp_stall_pct;

  initial begin
    clk = 1'b0;
  end

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic deq_result_t apply_deque_op(logic [deq_pkg::KIND_W-1:0] op,
                                                 deq_pkg::word_t word);
    deq_result_t r;
    r = '0;
    case (op)
      deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: begin
        if (held >= deq_pkg::DEPTH) begin
          r.overflow = 1'b1;
        end else if (op == deq_pkg::KIND_PUSH_FRONT) begin
          front_ptr = (front_ptr + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
          store[front_ptr] = word;
          held++;
        end else begin
          store[back_ptr] = word;
          back_ptr = (back_ptr + 1) % deq_pkg::DEPTH;
          held++;
        end
      end
      default: begin
        if (held == 0) begin
          r.underflow = 1'b1;
          r.popped = -32'sd1;
        end else if (op == deq_pkg::KIND_POP_FRONT) begin
          r.popped = store[front_ptr];
          front_ptr = (front_ptr + 1) % deq_pkg::DEPTH;
          held--;
        end else begin
          back_ptr = (back_ptr + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
          r.popped = store[back_ptr];
          held--;
        end
      end
    endcase
    r.occupancy = deq_pkg::OCC_W'(held);
    return r;
  endfunction

  function automatic void add_row(logic [deq_pkg::KIND_W-1:0] op, deq_pkg::word_t word,
                                  bit typed, deq_result_t exp);
    deq_row_t row;
    row.op = op;
    row.word = word;
    row.typed = typed;
    row.exp = exp;
    directed_rows[row_count] = row;
    row_count++;
  endfunction

  task automatic send_op(logic [deq_pkg::KIND_W-1:0] op, deq_pkg::word_t word, bit typed,
                         deq_result_t exp);
    deq_result_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    kind <= op;
    value <= word;
    do @(posedge clk); while (req_stall);
    predicted = apply_deque_op(op, word);
    expected_results[exp_wr % EXP_DEPTH] = typed ? exp : predicted;
    exp_wr++;
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
  end

  always @(posedge clk) begin
    deq_result_t exp;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (exp_rd == exp_wr) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response: popped=%0d uf=%0b of=%0b occ=%0d",
                   popped, underflow, overflow, occupancy);
      end else begin
        exp = expected_results[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (popped !== exp.popped || underflow !== exp.underflow ||
            overflow !== exp.overflow || occupancy !== exp.occupancy) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0b/%0b/%0d got %0d/%0b/%0b/%0d",
                     exp.popped, exp.underflow, exp.overflow, exp.occupancy,
                     popped, underflow, overflow, occupancy);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    deq_result_t none;
    deq_result_t full_push;
    deq_result_t empty_pop;
    logic [deq_pkg::KIND_W-1:0] op;
    deq_pkg::word_t word;
    int push_pct;
    int bias;

    rst = 1'b1;
    req_valid = 1'b0;
    kind = deq_pkg::KIND_PUSH_FRONT;
    value = '0;
    rsp_stall = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    rsp_stall_pct = 0;
    front_ptr = 0;
    back_ptr = 0;
    held = 0;
    exp_wr = 0;
    exp_rd = 0;
    row_count = 0;
    none = '0;
    empty_pop = '{popped: -32'sd1, underflow: 1'b1, overflow: 1'b0, occupancy: '0};
    full_push = '{popped: '0, underflow: 1'b0, overflow: 1'b1,
                  occupancy: deq_pkg::OCC_W'(deq_pkg::DEPTH)};

    // empty pops, extreme words in and out, then fill past full
    add_row(deq_pkg::KIND_POP_FRONT, 32'sh0, 1'b1, empty_pop);
    add_row(deq_pkg::KIND_POP_BACK, -32'sd1, 1'b1, empty_pop);
    add_row(deq_pkg::KIND_PUSH_FRONT, 32'sh8000_0000, 1'b1,
            '{'0, 1'b0, 1'b0, deq_pkg::OCC_W'(1)});
    add_row(deq_pkg::KIND_PUSH_BACK, 32'sh7fff_ffff, 1'b1,
            '{'0, 1'b0, 1'b0, deq_pkg::OCC_W'(2)});
    add_row(deq_pkg::KIND_POP_FRONT, 32'sh0, 1'b1,
            '{32'sh8000_0000, 1'b0, 1'b0, deq_pkg::OCC_W'(1)});
    add_row(deq_pkg::KIND_POP_BACK, 32'sh0, 1'b1,
            '{32'sh7fff_ffff, 1'b0, 1'b0, deq_pkg::OCC_W'(0)});
    for (int i = 0; i < deq_pkg::DEPTH; i++)
      add_row((i % 2) ? deq_pkg::KIND_PUSH_BACK : deq_pkg::KIND_PUSH_FRONT,
              (i % 2) ? ~(32'sh1 << i) : (32'sh1 << (i + 16)), 1'b0, none);
    add_row(deq_pkg::KIND_PUSH_FRONT, 32'sh1234_5678, 1'b1, full_push);
    add_row(deq_pkg::KIND_PUSH_BACK, -32'sd1, 1'b1, full_push);
    add_row(deq_pkg::KIND_POP_BACK, 32'sh0, 1'b0, none);
    add_row(deq_pkg::KIND_POP_FRONT, 32'sh0, 1'b0, none);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < row_count; i++)
      send_op(directed_rows[i].op, directed_rows[i].word, directed_rows[i].typed,
              directed_rows[i].exp);

    bias = 2;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin sender_idle_pct = 49; rsp_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  rsp_stall_pct = 49; end
        default: begin sender_idle_pct = 35; rsp_stall_pct = 35; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // drift between filling, draining and balanced runs to hit full and empty
        if (n % 40 == 0) bias = $urandom_range(2);
        push_pct = (bias == 0) ? 80 : (bias == 1) ? 20 : 50;
        if ($urandom_range(99) < push_pct)
          op = $urandom_range(1) ? deq_pkg::KIND_PUSH_BACK : deq_pkg::KIND_PUSH_FRONT;
        else
          op = $urandom_range(1) ? deq_pkg::KIND_POP_BACK : deq_pkg::KIND_POP_FRONT;
        case ($urandom_range(15))
          0: word = 32'sh8000_0000;
          1: word = 32'sh7fff_ffff;
          2: word = -32'sd1;
          3: word = 32'sh0;
          default: word = $urandom;
        endcase
        send_op(op, word, 1'b0, none);
      end
    end
    req_valid <= 1'b0;

    while (exp_rd != exp_wr) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
